// ===== hdl/lcar_pkg.sv =====
// Shared types, constants and microprogram for the load cell converter reader.
package lcar_pkg;

    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int AVG_W      = 24;
    localparam int WEIGHT_W   = 32;
    localparam int SCALE_W    = 32;
    localparam int SCALE_FRAC = 16;
    localparam int SUM_W      = 32;
    localparam int CNT_W      = 8;

    localparam logic [SCALE_W-1:0]  SCALE_RESET = 32'h0001_0000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX  = 32'h7FFF_FFFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN  = 32'h8000_0000;

    // Request codes; anything else is a tick.
    localparam logic [1:0] REQ_WEIGH = 2'd1;
    localparam logic [1:0] REQ_TARE  = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_HIGH,
        PH_LOW,
        PH_GAIN
    } phase_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FETCH,
        OP_DIV_AVG,
        OP_AVG,
        OP_DIV_WT,
        OP_WT,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_IN,
        COND_NOT_FIN,
        COND_DIV_BUSY,
        COND_TARE,
        COND_OUT_BLOCKED
    } cond_t;

    typedef enum logic [3:0] {
        ST_FETCH,
        ST_CHECK,
        ST_DIV_AVG,
        ST_WAIT_AVG,
        ST_AVG,
        ST_DIV_WT,
        ST_WAIT_WT,
        ST_WT,
        ST_EMIT
    } step_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t tgt_t;
        step_t tgt_f;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic finish;
        logic div_busy;
        logic tare;
        logic out_blocked;
    } seq_status_t;

    // Control store: jump to tgt_t when cond holds, else to tgt_f.
    function automatic ctrl_word_t microcode(input step_t step);
        ctrl_word_t w;
        unique case (step)
            ST_FETCH:    w = '{OP_FETCH,   COND_NO_IN,       ST_FETCH,    ST_CHECK};
            ST_CHECK:    w = '{OP_NONE,    COND_NOT_FIN,     ST_EMIT,     ST_DIV_AVG};
            ST_DIV_AVG:  w = '{OP_DIV_AVG, COND_ALWAYS,      ST_WAIT_AVG, ST_WAIT_AVG};
            ST_WAIT_AVG: w = '{OP_NONE,    COND_DIV_BUSY,    ST_WAIT_AVG, ST_AVG};
            ST_AVG:      w = '{OP_AVG,     COND_TARE,        ST_EMIT,     ST_DIV_WT};
            ST_DIV_WT:   w = '{OP_DIV_WT,  COND_ALWAYS,      ST_WAIT_WT,  ST_WAIT_WT};
            ST_WAIT_WT:  w = '{OP_NONE,    COND_DIV_BUSY,    ST_WAIT_WT,  ST_WT};
            ST_WT:       w = '{OP_WT,      COND_ALWAYS,      ST_EMIT,     ST_EMIT};
            ST_EMIT:     w = '{OP_EMIT,    COND_OUT_BLOCKED, ST_EMIT,     ST_FETCH};
            default:     w = '{OP_NONE,    COND_ALWAYS,      ST_FETCH,    ST_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/lcar_divider.sv =====
// Shared radix-2 restoring divider, one quotient bit per cycle.
module lcar_divider #(
    parameter int DIV_W = 49,
    parameter int DEN_W = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [DIV_W-1:0]                dividend,
    input  logic [DEN_W-1:0]                divisor,
    input  logic [$clog2(DIV_W+1)-1:0]      iters,
    output logic                            busy,
    output logic [DIV_W-1:0]                quotient
);

    localparam int ITER_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] trial_diff;
    logic           take;

    // Dividend is left-aligned; quotient bits shift in at the bottom.
    always_comb
    begin
        trial      = {rem_reg, num_reg[DIV_W-1]};
        trial_diff = trial - {1'b0, den_reg};
        take       = ~trial_diff[DEN_W];

        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            num_next = dividend;
            den_next = divisor;
            rem_next = '0;
            cnt_next = iters;
        end
        else if (cnt_reg != '0)
        begin
            num_next = {num_reg[DIV_W-2:0], take};
            rem_next = take ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = num_reg;

endmodule

// ===== hdl/lcar_sequencer.sv =====
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
module lcar_sequencer (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lcar_pkg::seq_status_t    status,
    output lcar_pkg::ctrl_word_t     ctrl
);

    lcar_pkg::step_t pc_reg, pc_next;
    logic            cond_true;

    always_comb
    begin
        ctrl = lcar_pkg::microcode(pc_reg);
        unique case (ctrl.cond)
            lcar_pkg::COND_ALWAYS:      cond_true = 1'b1;
            lcar_pkg::COND_NO_IN:       cond_true = ~status.in_valid;
            lcar_pkg::COND_NOT_FIN:     cond_true = ~status.finish;
            lcar_pkg::COND_DIV_BUSY:    cond_true = status.div_busy;
            lcar_pkg::COND_TARE:        cond_true = status.tare;
            lcar_pkg::COND_OUT_BLOCKED: cond_true = status.out_blocked;
            default:                    cond_true = 1'b1;
        endcase
        pc_next = cond_true ? ctrl.tgt_t : ctrl.tgt_f;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= lcar_pkg::ST_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== hdl/load_cell_adc_reader.sv =====
// Top level: converter clocking, bit sampling, averaging, tare and scaling datapath.
//
//  channel  direction  handshake              payload
//  in       in         in_valid / in_ready    req_type, dout_level, sample_count
//  out      out        out_valid / out_ready  sck_level, done_res, was_tare,
//                                             weight_value, average_raw, busy_res
//  cfg      in         cfg_valid / cfg_ready  scale_factor
//
// A plain tick runs fetch, check and emit. The tick that ends the last conversion
// of a tare also runs the mean division; that of a weighing runs the mean and then
// the weight division on the shared bit-serial divider: 32 quotient bits for the mean,
// then 41 + FRACTION_BITS quotient bits for the scaled weight.
// Reset: sequencer at fetch, converter idle, offset 0, scale 1.0 in Q16.16.
// A new item is taken while the previous result still waits; the emit step
// holds until the output register is free. cfg_ready is always high.
module load_cell_adc_reader #(
    parameter int SAMPLE_BITS   = lcar_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = lcar_pkg::FRACTION_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          req_type,
    input  logic                dout_level,
    input  logic [7:0]          sample_count,

    output logic                out_valid,
    input  logic                out_ready,
    output logic                sck_level,
    output logic                done_res,
    output logic                was_tare,
    output logic signed [31:0]  weight_value,
    output logic signed [23:0]  average_raw,
    output logic                busy_res,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic signed [31:0]  scale_factor
);

    localparam int AVG_W      = lcar_pkg::AVG_W;
    localparam int WEIGHT_W   = lcar_pkg::WEIGHT_W;
    localparam int SCALE_W    = lcar_pkg::SCALE_W;
    localparam int SUM_W      = lcar_pkg::SUM_W;
    localparam int CNT_W      = lcar_pkg::CNT_W;
    localparam int FRAC_SHIFT = lcar_pkg::SCALE_FRAC + FRACTION_BITS;
    localparam int DIFF_W     = AVG_W + 1;
    localparam int DIV_W      = DIFF_W + FRAC_SHIFT;
    localparam int ITER_W     = $clog2(DIV_W + 1);
    localparam int BCNT_W     = $clog2(SAMPLE_BITS + 1);

    lcar_pkg::ctrl_word_t  ctrl;
    lcar_pkg::seq_status_t status;

    // Converter and accumulation state
    lcar_pkg::phase_t        phase_reg, phase_next;
    logic [BCNT_W-1:0]       bitcnt_reg, bitcnt_next;
    logic [SAMPLE_BITS-1:0]  shift_reg, shift_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [CNT_W-1:0]        done_cnt_reg, done_cnt_next;
    logic [CNT_W-1:0]        wanted_reg, wanted_next;
    logic                    tare_reg, tare_next;
    logic                    fin_reg, fin_next;
    logic [AVG_W-1:0]        offset_reg, offset_next;
    logic [SCALE_W-1:0]      scale_reg;

    // Arithmetic results
    logic [AVG_W-1:0]        avg_reg, avg_next;
    logic                    neg_reg, neg_next;
    logic [WEIGHT_W-1:0]     weight_reg, weight_next;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic                    sck_reg, done_reg, was_tare_reg, busy_reg;
    logic [WEIGHT_W-1:0]     weight_out_reg;
    logic [AVG_W-1:0]        avg_out_reg;

    logic                    in_xfer;
    logic                    is_start;
    logic [BCNT_W-1:0]       bitcnt_inc;
    logic [CNT_W-1:0]        done_inc;
    logic [SUM_W-1:0]        sample_ext;

    logic                    div_start;
    logic                    div_busy;
    logic [DIV_W-1:0]        div_dividend;
    logic [SCALE_W-1:0]      div_divisor;
    logic [ITER_W-1:0]       div_iters;
    logic [DIV_W-1:0]        div_quot;

    logic [SUM_W-1:0]        sum_mag;
    logic [DIFF_W-1:0]       diff;
    logic [DIFF_W-1:0]       diff_mag;
    logic [SCALE_W-1:0]      scale_mag;
    logic [AVG_W-1:0]        avg_q;
    logic [WEIGHT_W-1:0]     q_low;
    logic                    q_big;

    logic                    out_blocked;
    logic                    out_load;

    lcar_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    lcar_divider #(
        .DIV_W (DIV_W),
        .DEN_W (SCALE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    assign in_ready    = (ctrl.op == lcar_pkg::OP_FETCH);
    assign in_xfer     = in_valid & in_ready;
    assign out_blocked = out_valid_reg & ~out_ready;
    assign out_load    = (ctrl.op == lcar_pkg::OP_EMIT) & ~out_blocked;
    assign cfg_ready   = 1'b1;

    always_comb
    begin
        status.in_valid    = in_valid;
        status.finish      = fin_reg;
        status.div_busy    = div_busy;
        status.tare        = tare_reg;
        status.out_blocked = out_blocked;
    end

    // Converter phase machine, one step per accepted item
    always_comb
    begin
        is_start   = (req_type == lcar_pkg::REQ_WEIGH) || (req_type == lcar_pkg::REQ_TARE);
        bitcnt_inc = bitcnt_reg + 1'b1;
        done_inc   = done_cnt_reg + 1'b1;
        sample_ext = {{(SUM_W-SAMPLE_BITS){shift_reg[SAMPLE_BITS-1]}}, shift_reg};

        phase_next    = phase_reg;
        bitcnt_next   = bitcnt_reg;
        shift_next    = shift_reg;
        sum_next      = sum_reg;
        done_cnt_next = done_cnt_reg;
        wanted_next   = wanted_reg;
        tare_next     = tare_reg;
        fin_next      = fin_reg;

        if (in_xfer)
        begin
            fin_next = 1'b0;
            if (is_start)
            begin
                // a start while busy is dropped
                if (phase_reg == lcar_pkg::PH_IDLE)
                begin
                    wanted_next   = (sample_count == '0) ? CNT_W'(1) : sample_count;
                    done_cnt_next = '0;
                    sum_next      = '0;
                    tare_next     = (req_type == lcar_pkg::REQ_TARE);
                    bitcnt_next   = '0;
                    shift_next    = '0;
                    phase_next    = lcar_pkg::PH_WAIT;
                end
            end
            else
            begin
                unique case (phase_reg)
                    lcar_pkg::PH_IDLE:
                    begin
                        phase_next = lcar_pkg::PH_IDLE;
                    end
                    lcar_pkg::PH_WAIT:
                    begin
                        if (!dout_level)
                        begin
                            bitcnt_next = '0;
                            shift_next  = '0;
                            phase_next  = lcar_pkg::PH_HIGH;
                        end
                    end
                    lcar_pkg::PH_HIGH:
                    begin
                        phase_next = lcar_pkg::PH_LOW;
                    end
                    lcar_pkg::PH_LOW:
                    begin
                        shift_next  = {shift_reg[SAMPLE_BITS-2:0], dout_level};
                        bitcnt_next = bitcnt_inc;
                        phase_next  = (bitcnt_inc < BCNT_W'(SAMPLE_BITS)) ?
                                      lcar_pkg::PH_HIGH : lcar_pkg::PH_GAIN;
                    end
                    lcar_pkg::PH_GAIN:
                    begin
                        sum_next      = sum_reg + sample_ext;
                        done_cnt_next = done_inc;
                        if (done_inc >= wanted_reg)
                        begin
                            fin_next   = 1'b1;
                            phase_next = lcar_pkg::PH_IDLE;
                        end
                        else
                        begin
                            phase_next = lcar_pkg::PH_WAIT;
                        end
                    end
                    default:
                    begin
                        phase_next = lcar_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Mean and weight arithmetic around the shared divider
    always_comb
    begin
        sum_mag   = sum_reg[SUM_W-1] ? (SUM_W'(0) - sum_reg) : sum_reg;
        diff      = {avg_reg[AVG_W-1], avg_reg} - {offset_reg[AVG_W-1], offset_reg};
        diff_mag  = diff[DIFF_W-1] ? (DIFF_W'(0) - diff) : diff;
        scale_mag = scale_reg[SCALE_W-1] ? (SCALE_W'(0) - scale_reg) : scale_reg;

        div_start = (ctrl.op == lcar_pkg::OP_DIV_AVG) || (ctrl.op == lcar_pkg::OP_DIV_WT);
        if (ctrl.op == lcar_pkg::OP_DIV_WT)
        begin
            div_dividend = {diff_mag, FRAC_SHIFT'(0)};
            div_divisor  = scale_mag;
            div_iters    = ITER_W'(DIV_W);
        end
        else
        begin
            div_dividend = {sum_mag, (DIV_W-SUM_W)'(0)};
            div_divisor  = SCALE_W'(wanted_reg);
            div_iters    = ITER_W'(SUM_W);
        end

        // |mean| <= 2^23, so the low bits of the quotient carry it
        avg_q = div_quot[AVG_W-1:0];
        q_low = div_quot[WEIGHT_W-1:0];
        q_big = |div_quot[DIV_W-1:WEIGHT_W-1];

        avg_next    = avg_reg;
        offset_next = offset_reg;
        neg_next    = neg_reg;
        weight_next = weight_reg;

        if (ctrl.op == lcar_pkg::OP_AVG)
        begin
            avg_next = sum_reg[SUM_W-1] ? (AVG_W'(0) - avg_q) : avg_q;
            if (tare_reg)
            begin
                offset_next = avg_next;
            end
        end
        if (ctrl.op == lcar_pkg::OP_DIV_WT)
        begin
            neg_next = diff[DIFF_W-1] ^ scale_reg[SCALE_W-1];
        end
        if (ctrl.op == lcar_pkg::OP_WT)
        begin
            if (neg_reg)
            begin
                weight_next = q_big ? lcar_pkg::WEIGHT_MIN : (WEIGHT_W'(0) - q_low);
            end
            else
            begin
                weight_next = q_big ? lcar_pkg::WEIGHT_MAX : q_low;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lcar_pkg::PH_IDLE;
            bitcnt_reg    <= '0;
            shift_reg     <= '0;
            sum_reg       <= '0;
            done_cnt_reg  <= '0;
            wanted_reg    <= CNT_W'(1);
            tare_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            offset_reg    <= '0;
            scale_reg     <= lcar_pkg::SCALE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            bitcnt_reg    <= bitcnt_next;
            shift_reg     <= shift_next;
            sum_reg       <= sum_next;
            done_cnt_reg  <= done_cnt_next;
            wanted_reg    <= wanted_next;
            tare_reg      <= tare_next;
            fin_reg       <= fin_next;
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
            // a zero scale would leave the divisor at zero: drop it
            if (cfg_valid && (scale_factor != '0))
            begin
                scale_reg <= scale_factor;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg    <= avg_next;
        neg_reg    <= neg_next;
        weight_reg <= weight_next;
        if (out_load)
        begin
            sck_reg        <= (phase_reg == lcar_pkg::PH_HIGH) ||
                              (phase_reg == lcar_pkg::PH_GAIN);
            done_reg       <= fin_reg;
            was_tare_reg   <= fin_reg & tare_reg;
            weight_out_reg <= (fin_reg && !tare_reg) ? weight_reg : '0;
            avg_out_reg    <= fin_reg ? avg_reg : '0;
            busy_reg       <= (phase_reg != lcar_pkg::PH_IDLE);
        end
    end

    assign out_valid    = out_valid_reg;
    assign sck_level    = sck_reg;
    assign done_res     = done_reg;
    assign was_tare     = was_tare_reg;
    assign weight_value = weight_out_reg;
    assign average_raw  = avg_out_reg;
    assign busy_res     = busy_reg;

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((ctrl.op == lcar_pkg::OP_DIV_AVG) || (ctrl.op == lcar_pkg::OP_DIV_WT)) |-> !div_busy)
        else $error("divider restarted while busy");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken before the first was emitted");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (!busy_res && !sck_level))
        else $error("finished result reports a busy converter");

    a_scale_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        scale_reg != '0)
        else $error("scale register holds zero");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the load cell converter reader: stimulus, weight predictor, checks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 100;   // covers the slowest item (weighing end)
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEM_TARGET    = 1550;
    localparam int CFG_SPACING    = 300;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_SPARE = 2'd3;   // unused code, behaves as a tick

    typedef struct packed {
        logic               sck;
        logic               done;
        logic               tare;
        logic signed [31:0] weight;
        logic signed [23:0] avg;
        logic               busy;
    } reading_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         req_type = REQ_TICK;
    logic               dout_level = 1'b1;
    logic [7:0]         sample_count = 8'd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               sck_level;
    logic               done_res;
    logic               was_tare;
    logic signed [31:0] weight_value;
    logic signed [23:0] average_raw;
    logic               busy_res;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic signed [31:0] scale_factor = lcar_pkg::SCALE_RESET;

    // predictor state
    lcar_pkg::phase_t   ph = lcar_pkg::PH_IDLE;
    logic [4:0]         bit_cnt = '0;
    logic [23:0]        shift = '0;
    logic [31:0]        acc = '0;
    logic [7:0]         conv_done = '0;
    logic [7:0]         wanted = 8'd1;
    logic               tare_pending = 1'b0;
    logic [23:0]        offset = '0;
    logic signed [31:0] scale_model = lcar_pkg::SCALE_RESET;

    reading_t           expected_readings[$];
    int                 mismatches = 0;
    int                 items_sent = 0;
    int                 idle_cycles = 0;
    bit                 src_steady = 1'b0;
    bit                 sink_steady = 1'b0;
    bit                 hold_rq = 1'b0;

    load_cell_adc_reader u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .dout_level   (dout_level),
        .sample_count (sample_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sck_level    (sck_level),
        .done_res     (done_res),
        .was_tare     (was_tare),
        .weight_value (weight_value),
        .average_raw  (average_raw),
        .busy_res     (busy_res),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .scale_factor (scale_factor)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [23:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'h800000;
            3: return 24'h7FFFFF;
            4: return 24'($urandom_range(0, 15));
            5: return 24'hFFFFF0 | 24'($urandom_range(0, 15));
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [1:0] tick_code();
        return ($urandom_range(0, 4) == 0) ? REQ_SPARE : REQ_TICK;
    endfunction

    // (avg - offset) * 2^(16+frac) / scale, truncated toward zero, saturated to Q24.8
    function automatic logic signed [31:0] scaled_weight(input int mean,
                                                         input logic signed [23:0] off,
                                                         input logic signed [31:0] sc);
        longint          diff;
        longint          sc_wide;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        bit              neg;
        diff    = longint'(mean) - longint'(off);
        sc_wide = longint'(sc);
        neg     = (diff < 0) != (sc_wide < 0);
        num     = (diff < 0) ? -diff : diff;
        num     = num << (lcar_pkg::SCALE_FRAC + lcar_pkg::FRACTION_BITS_DEF);
        den     = (sc_wide < 0) ? -sc_wide : sc_wide;
        q       = num / den;
        if (q == 0)
            return '0;
        if (neg)
        begin
            if (q >= 64'h8000_0000)
                return lcar_pkg::WEIGHT_MIN;
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF)
            return lcar_pkg::WEIGHT_MAX;
        return 32'(q);
    endfunction

    function automatic reading_t predict_reading(input logic [1:0] rq, input logic d,
                                                 input logic [7:0] c);
        reading_t r;
        int       mean;
        r = '0;
        if (rq == lcar_pkg::REQ_WEIGH || rq == lcar_pkg::REQ_TARE)
        begin
            if (ph == lcar_pkg::PH_IDLE)
            begin
                wanted       = (c == 8'd0) ? 8'd1 : c;
                conv_done    = '0;
                acc          = '0;
                tare_pending = (rq == lcar_pkg::REQ_TARE);
                bit_cnt      = '0;
                shift        = '0;
                ph           = lcar_pkg::PH_WAIT;
            end
        end
        else
        begin
            case (ph)
                lcar_pkg::PH_WAIT:
                    if (!d)
                    begin
                        bit_cnt = '0;
                        shift   = '0;
                        ph      = lcar_pkg::PH_HIGH;
                    end
                lcar_pkg::PH_HIGH:
                    ph = lcar_pkg::PH_LOW;
                lcar_pkg::PH_LOW:
                begin
                    shift   = {shift[22:0], d};
                    bit_cnt = bit_cnt + 5'd1;
                    if (bit_cnt < lcar_pkg::SAMPLE_BITS_DEF)
                        ph = lcar_pkg::PH_HIGH;
                    else
                        ph = lcar_pkg::PH_GAIN;
                end
                lcar_pkg::PH_GAIN:
                begin
                    acc       = acc + {{8{shift[23]}}, shift};
                    conv_done = conv_done + 8'd1;
                    if (conv_done >= wanted)
                    begin
                        mean   = $signed(acc) / $signed({24'd0, wanted});
                        r.done = 1'b1;
                        r.tare = tare_pending;
                        r.avg  = mean[23:0];
                        if (tare_pending)
                            offset = mean[23:0];
                        else
                            r.weight = scaled_weight(mean, offset, scale_model);
                        ph = lcar_pkg::PH_IDLE;
                    end
                    else
                        ph = lcar_pkg::PH_WAIT;
                end
                default:
                    ph = lcar_pkg::PH_IDLE;
            endcase
        end
        r.sck  = (ph == lcar_pkg::PH_HIGH) || (ph == lcar_pkg::PH_GAIN);
        r.busy = (ph != lcar_pkg::PH_IDLE);
        return r;
    endfunction

    task automatic send_item(input logic [1:0] rq, input logic d, input logic [7:0] c);
        int gap;
        bit is_start;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= rq;
        dout_level   <= d;
        sample_count <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        // starts while busy and ticks while idle leave the block untouched
        is_start = (rq == lcar_pkg::REQ_WEIGH) || (rq == lcar_pkg::REQ_TARE);
        if (is_start ? (ph == lcar_pkg::PH_IDLE) : (ph != lcar_pkg::PH_IDLE))
            items_sent++;
        expected_readings.push_back(predict_reading(rq, d, c));
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_scale(input logic [31:0] value);
        drain_pipeline();
        cfg_valid    <= 1'b1;
        scale_factor <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (value != 32'd0)
            scale_model = value;
        cfg_valid <= 1'b0;
    endtask

    // one converter word: wait for DOUT low, 24 clocked bits, gain pulse
    task automatic run_conversion(input logic [23:0] word, input int wait_ticks);
        repeat (wait_ticks) send_item(tick_code(), 1'b1, 8'($urandom()));
        send_item(tick_code(), 1'b0, 8'($urandom()));
        for (int i = lcar_pkg::SAMPLE_BITS_DEF - 1; i >= 0; i--)
        begin
            if (ph != lcar_pkg::PH_IDLE && $urandom_range(0, 29) == 0)
                send_item($urandom_range(0, 1) ? lcar_pkg::REQ_WEIGH : lcar_pkg::REQ_TARE,
                          1'($urandom()), 8'($urandom()));
            send_item(tick_code(), 1'($urandom()), 8'($urandom()));
            send_item(tick_code(), word[i], 8'($urandom()));
        end
        send_item(tick_code(), 1'($urandom()), 8'($urandom()));
    endtask

    task automatic run_operation(input logic [1:0] rq, input logic [7:0] cnt);
        int n;
        n = (cnt == 8'd0) ? 1 : cnt;
        send_item(rq, 1'($urandom()), cnt);
        repeat (n) run_conversion(pick_word(), $urandom_range(0, 3));
    endtask

    task automatic send_noise(input int count);
        logic [1:0] rq;
        logic [7:0] c;
        repeat (count)
        begin
            rq = 2'($urandom_range(0, 3));
            if ((rq == lcar_pkg::REQ_WEIGH || rq == lcar_pkg::REQ_TARE) &&
                ph == lcar_pkg::PH_IDLE)
                c = 8'($urandom_range(0, 3));
            else
                c = 8'($urandom());
            send_item(rq, 1'($urandom()), c);
        end
    endtask

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(0, 8))
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'd0;
            5: return lcar_pkg::SCALE_RESET;
            6: return 32'($urandom_range(1, 1 << 20));
            7: return -32'($urandom_range(1, 1 << 20));
            default: return $urandom();
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_reading();
        reading_t want;
        if (expected_readings.size() == 0)
        begin
            $display("%0t: result with no expected value, expected none actual weight %h",
                     $time, weight_value);
            mismatches++;
        end
        else
        begin
            want = expected_readings.pop_front();
            compare_field("sck_level", want.sck, sck_level);
            compare_field("done_res", want.done, done_res);
            compare_field("was_tare", want.tare, was_tare);
            compare_field("weight_value", want.weight, weight_value);
            compare_field("average_raw", want.avg, average_raw);
            compare_field("busy_res", want.busy, busy_res);
        end
    endtask

    task automatic test_scale_register();
        write_scale(32'd0);          // ignored, scale stays 1.0
        write_scale(lcar_pkg::SCALE_RESET);
    endtask

    task automatic test_special_items();
        send_item(REQ_TICK, 1'b0, 8'd0);
        send_item(REQ_TICK, 1'b1, 8'hFF);
        send_item(REQ_SPARE, 1'b0, 8'd0);
        send_item(REQ_SPARE, 1'b1, 8'hAA);
        send_item(lcar_pkg::REQ_WEIGH, 1'b0, 8'd0);    // zero count runs one conversion
        send_item(lcar_pkg::REQ_TARE, 1'b1, 8'hFF);    // busy: dropped
        send_item(lcar_pkg::REQ_WEIGH, 1'b0, 8'h80);   // busy: dropped
        send_item(REQ_TICK, 1'b1, 8'h55);
        send_item(REQ_SPARE, 1'b1, 8'h7F);
        run_conversion(24'h123456, 0);
        send_item(lcar_pkg::REQ_TARE, 1'b0, 8'd1);
        run_conversion(24'h000000, 1);
    endtask

    task automatic test_extremes();
        send_item(lcar_pkg::REQ_WEIGH, 1'b0, 8'd1);
        run_conversion(24'h7FFFFF, 0);
        send_item(lcar_pkg::REQ_WEIGH, 1'b1, 8'd1);
        run_conversion(24'h800000, 2);
        send_item(lcar_pkg::REQ_TARE, 1'b0, 8'd1);
        run_conversion(24'h800000, 0);
        send_item(lcar_pkg::REQ_WEIGH, 1'b0, 8'd1);
        run_conversion(24'h7FFFFF, 0);
        write_scale(32'hFFFF_FFFF);
        send_item(lcar_pkg::REQ_WEIGH, 1'b0, 8'd1);
        run_conversion(24'h000000, 0);
        write_scale(32'h7FFF_FFFF);
        send_item(lcar_pkg::REQ_WEIGH, 1'b0, 8'd3);
        run_conversion(24'h7FFFFF, 0);
        run_conversion(24'h7FFFFF, 1);
        run_conversion(24'h7FFFFE, 0);
        write_scale(32'h8000_0000);
        send_item(lcar_pkg::REQ_WEIGH, 1'b0, 8'd1);
        run_conversion(24'hFFFFFF, 0);
        write_scale(32'd1);
        send_item(lcar_pkg::REQ_TARE, 1'b0, 8'd1);
        run_conversion(24'h7FFFFF, 0);
        send_item(lcar_pkg::REQ_WEIGH, 1'b0, 8'd1);
        run_conversion(24'h800000, 0);
        write_scale(lcar_pkg::SCALE_RESET);
    endtask

    task automatic test_output_stall();
        drain_pipeline();
        hold_rq    = 1'b1;
        src_steady = 1'b1;
        run_operation(lcar_pkg::REQ_WEIGH, 8'd1);
        src_steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        int         next_cfg_at;
        int         r;
        logic [7:0] cnt;
        next_cfg_at = items_sent + CFG_SPACING;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= next_cfg_at)
            begin
                write_scale(pick_scale());
                next_cfg_at = items_sent + CFG_SPACING;
            end
            src_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 85)
            begin
                r = $urandom_range(0, 99);
                if (r < 25)
                    cnt = 8'd0;
                else if (r < 60)
                    cnt = 8'd1;
                else if (r < 85)
                    cnt = 8'd2;
                else if (r < 95)
                    cnt = 8'd3;
                else
                    cnt = 8'($urandom_range(4, 5));
                run_operation(($urandom_range(0, 9) < 7) ?
                              lcar_pkg::REQ_WEIGH : lcar_pkg::REQ_TARE, cnt);
            end
            else
                send_noise($urandom_range(1, 10));
        end
        src_steady = 1'b0;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_scale_register();
        test_special_items();
        test_extremes();
        test_output_stall();
        test_random_traffic();
        drain_pipeline();
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // output side: random back-pressure, long hold on request, result checks
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                check_reading();
                if (!sink_steady)
                    stall_left = pick_gap();
                if ($urandom_range(0, 39) == 0)
                    sink_steady = !sink_steady;
            end
            if (hold_rq)
            begin
                stall_left = HOLD_CYCLES;
                hold_rq    = 1'b0;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
